### rtl/sat_pkg.sv
package sat_pkg;

  localparam int ARENA_LOG2 = 20;
  localparam int PARA_SHIFT = 4;
  localparam int PAGE_SHIFT = 16;
  localparam int ENTRY_W    = 64 - PAGE_SHIFT;

  localparam logic [63:0] ARENA_BYTES   = 64'(1) << ARENA_LOG2;
  localparam logic [15:0] EXT_FIRST_SEG = 16'hE000;

  localparam logic CMD_TO_FAR  = 1'b0;
  localparam logic CMD_TO_HOST = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [63:0] host_address;
    logic [15:0] segment;
    logic [15:0] offset;
  } req_t;

  typedef struct packed {
    logic [63:0] host_result;
    logic [15:0] segment_result;
    logic [15:0] offset_result;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [1:0] {
    RES_DIRECT = 2'd0,
    RES_HIT    = 2'd1,
    RES_NEW    = 2'd2,
    RES_LOOKUP = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     start_scan;
    logic     scan_step;
    logic     load_res;
    res_sel_t res_sel;
    logic     push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic direct;
    logic is_far;
    logic hit;
    logic scan_done;
    logic out_free;
  } ctrl_status_t;

endpackage

### rtl/sat_ram.sv
module sat_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sat_datapath.sv
module sat_datapath import sat_pkg::*; #(
  parameter int PAGE_SLOTS = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  req_t         req_item,
  input  logic         cfg_valid,
  input  logic [63:0]  cfg_data,
  input  logic         rsp_stall,
  output logic         rsp_valid,
  output rsp_t         rsp_item,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status
);

  localparam int IDX_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int PU_W  = $clog2(PAGE_SLOTS + 1);

  req_t              item;
  logic [63:0]       arena_base;
  logic [PU_W-1:0]   pages_used;
  logic [PU_W-1:0]   scan_idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;
  rsp_t              res;
  rsp_t              res_next;

  logic [ENTRY_W-1:0] key;
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [64:0]        rel_full;
  logic               in_arena;
  logic               far_null;
  logic               host_null;
  logic               seg_ext;
  logic [15:0]        lookup_idx;
  logic               idx_ok;
  logic               issue;
  logic               full;
  logic               ram_we;

  assign key       = item.host_address[63:PAGE_SHIFT];
  assign rel_full  = {1'b0, item.host_address} - {1'b0, arena_base};
  assign in_arena  = !rel_full[64] && (rel_full[63:ARENA_LOG2] == '0);
  assign far_null  = (item.host_address == '0);
  assign host_null = (item.segment == '0) && (item.offset == '0);
  assign seg_ext   = (item.segment >= EXT_FIRST_SEG);
  assign lookup_idx = item.segment - EXT_FIRST_SEG;
  assign idx_ok    = lookup_idx < 16'(pages_used);
  assign issue     = scan_idx < pages_used;
  assign full      = (pages_used == PU_W'(PAGE_SLOTS));
  assign rd_addr   = cmd.scan_step ? scan_idx[IDX_W-1:0] : lookup_idx[IDX_W-1:0];
  assign ram_we    = cmd.load_res && (cmd.res_sel == RES_NEW) && !full;

  sat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAGE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pages_used[IDX_W-1:0]),
    .wdata (key),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    status.is_far    = (item.cmd == CMD_TO_FAR);
    status.direct    = (item.cmd == CMD_TO_FAR) ? (far_null || in_arena)
                                                : !(seg_ext && idx_ok);
    status.hit       = cmp_valid && (rd_data == key);
    status.scan_done = !cmp_valid && !issue;
    status.out_free  = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    res_next = '0;
    case (cmd.res_sel)
      RES_DIRECT: begin
        if (item.cmd == CMD_TO_FAR) begin
          if (!far_null) begin
            res_next.segment_result = rel_full[ARENA_LOG2-1:PARA_SHIFT];
            res_next.offset_result  = 16'(rel_full[PARA_SHIFT-1:0]);
          end
        end else if (host_null) begin
          res_next = '0;
        end else if (seg_ext) begin
          res_next.status = ST_BAD_INDEX;
        end else begin
          res_next.host_result = arena_base + 64'({item.segment, 4'b0000})
                                 + 64'(item.offset);
        end
      end
      RES_HIT: begin
        res_next.segment_result = EXT_FIRST_SEG + 16'(cmp_idx);
        res_next.offset_result  = item.host_address[15:0];
      end
      RES_NEW: begin
        if (full) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.segment_result = EXT_FIRST_SEG + 16'(pages_used);
          res_next.offset_result  = item.host_address[15:0];
        end
      end
      RES_LOOKUP: begin
        res_next.host_result = {rd_data, item.offset};
      end
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_base <= ARENA_BYTES;
      pages_used <= '0;
      scan_idx   <= '0;
      cmp_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        arena_base <= cfg_data;
      end
      if (ram_we) begin
        pages_used <= pages_used + PU_W'(1);
      end
      if (cmd.start_scan) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_valid <= issue;
        if (issue) begin
          scan_idx <= scan_idx + PU_W'(1);
        end
      end
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req_item;
    end
    if (cmd.scan_step) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.load_res) begin
      res <= res_next;
    end
    if (cmd.push) begin
      rsp_item <= res;
    end
  end

endmodule

### rtl/sat_ctrl.sv
module sat_ctrl import sat_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    IDLE      = 5'b00001,
    CLASSIFY  = 5'b00010,
    SCAN      = 5'b00100,
    READ_WAIT = 5'b01000,
    HOLD      = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel = RES_DIRECT;
    case (state)
      IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = CLASSIFY;
        end
      end
      CLASSIFY: begin
        if (status.direct) begin
          cmd.load_res = 1'b1;
          state_next   = HOLD;
        end else if (status.is_far) begin
          cmd.start_scan = 1'b1;
          state_next     = SCAN;
        end else begin
          state_next = READ_WAIT;
        end
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.hit) begin
          cmd.load_res = 1'b1;
          cmd.res_sel  = RES_HIT;
          state_next   = HOLD;
        end else if (status.scan_done) begin
          cmd.load_res = 1'b1;
          cmd.res_sel  = RES_NEW;
          state_next   = HOLD;
        end
      end
      READ_WAIT: begin
        cmd.load_res = 1'b1;
        cmd.res_sel  = RES_LOOKUP;
        state_next   = HOLD;
      end
      HOLD: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/segment_address_translator_top.sv
// Converts 64-bit host addresses to 16:16 segment:offset pairs (cmd 0) and
// back (cmd 1). Addresses inside the 1 MiB arena at arena_base map to
// paragraph segments; other addresses are registered as 64 KiB pages in a
// table of PAGE_SLOTS entries and appear as segment 0xE000 plus the table
// index. One item is in flight at a time. Null and arena items, and to_host
// items that do not read the page table, go from CLASSIFY straight to HOLD;
// a to_host that reads the page table passes through READ_WAIT first. A to_far
// outside the arena scans the page table one entry per cycle through the
// table memory's single read port; result-channel stalls hold the result in
// HOLD. A full table answers status 2, an unregistered page index status 1.
// arena_base may be written at any time the block is idle; cfg_ready is
// always high. No clearing pass is needed after reset.
module segment_address_translator_top import sat_pkg::*; #(
  parameter int PAGE_SLOTS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_item,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  sat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sat_datapath #(
    .PAGE_SLOTS (PAGE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_item  (rsp_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### rtl/sat_checker.sv
module sat_checker import sat_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input req_t        req_item,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input rsp_t        rsp_item,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [63:0] cfg_data
);

  // one item at a time: an accepted item blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item accepted while another in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_item.status == ST_OK || rsp_item.status == ST_BAD_INDEX
                  || rsp_item.status == ST_FULL)
    else $error("bad status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.status != ST_OK |->
      rsp_item.host_result == '0 && rsp_item.segment_result == '0
      && rsp_item.offset_result == '0)
    else $error("error result carries data");

endmodule

bind segment_address_translator_top sat_checker u_sat_checker (.*);

### sim/tb_segment_address_translator_top.sv
import sat_pkg::*;

class translation_scoreboard #(int SLOTS = 512);
  logic [63:0] arena_base;
  logic [47:0] page_keys [SLOTS];
  int unsigned pages_used;
  rsp_t        expected_translations [$];
  int unsigned mismatches;

  function new();
    arena_base = ARENA_BYTES;
    pages_used = 0;
    mismatches = 0;
  endfunction

  function rsp_t translate(req_t r);
    rsp_t        o;
    logic [63:0] rel;
    logic [47:0] key;
    logic [15:0] idx;
    o = '0;
    o.status = ST_OK;
    if (r.cmd == CMD_TO_FAR) begin
      if (r.host_address == '0) return o;
      if (r.host_address >= arena_base && r.host_address - arena_base < ARENA_BYTES) begin
        rel = r.host_address - arena_base;
        o.segment_result = rel[19:4];
        o.offset_result  = {12'h0, rel[3:0]};
        return o;
      end
      key = r.host_address[63:16];
      for (int i = 0; i < int'(pages_used); i++) begin
        if (page_keys[i] == key) begin
          o.segment_result = EXT_FIRST_SEG + 16'(i);
          o.offset_result  = r.host_address[15:0];
          return o;
        end
      end
      if (pages_used >= SLOTS) begin
        o.status = ST_FULL;
        return o;
      end
      page_keys[pages_used] = key;
      o.segment_result = EXT_FIRST_SEG + 16'(pages_used);
      o.offset_result  = r.host_address[15:0];
      pages_used++;
      return o;
    end
    if (r.segment == '0 && r.offset == '0) return o;
    if (r.segment >= EXT_FIRST_SEG) begin
      idx = r.segment - EXT_FIRST_SEG;
      if (idx >= pages_used) o.status = ST_BAD_INDEX;
      else o.host_result = {page_keys[idx], r.offset};
      return o;
    end
    o.host_result = arena_base + {44'h0, r.segment, 4'h0} + 64'(r.offset);
    return o;
  endfunction

  function void note_request(req_t r);
    expected_translations.push_back(translate(r));
  endfunction

  function void log_mismatch(string what, rsp_t want, rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected host %h seg %h off %h st %0d, got host %h seg %h off %h st %0d",
               what, want.host_result, want.segment_result, want.offset_result, want.status,
               got.host_result, got.segment_result, got.offset_result, got.status);
    end
  endfunction

  function void check_response(rsp_t got);
    rsp_t want;
    if (expected_translations.size() == 0) begin
      log_mismatch("unexpected item", '0, got);
      return;
    end
    want = expected_translations.pop_front();
    if (got.host_result !== want.host_result || got.segment_result !== want.segment_result ||
        got.offset_result !== want.offset_result || got.status !== want.status) begin
      log_mismatch("mismatch", want, got);
    end
  endfunction
endclass

module tb_segment_address_translator_top;

  localparam int          SLOTS          = 512;
  localparam logic [63:0] ARENA_BASE_MIN = 64'd16;
  localparam logic [63:0] ARENA_BASE_MAX = 64'hFFFF_FFFF_FFE0_0000;
  localparam int unsigned CYCLE_LIMIT    = 3_000_000;
  localparam int          HOLD_CYCLES    = 2500;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_item  = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data  = '0;

  translation_scoreboard #(SLOTS) sb;

  int          burst_left   = 0;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  int          hold_left    = 0;
  int          mode_left    = 0;
  stall_mode_t stall_mode   = STALL_NONE;
  int unsigned cycle_count  = 0;

  segment_address_translator_top #(.PAGE_SLOTS(SLOTS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp_item);
  end

  // receiver back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  rsp_stall <= 1'b0;
        STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
        default:     rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  function automatic req_t far_req(logic [63:0] addr);
    req_t r;
    r.cmd          = CMD_TO_FAR;
    r.host_address = addr;
    r.segment      = 16'($urandom);
    r.offset       = 16'($urandom);
    return r;
  endfunction

  function automatic req_t host_req(logic [15:0] seg, logic [15:0] off);
    req_t r;
    r.cmd          = CMD_TO_HOST;
    r.host_address = {$urandom, $urandom};
    r.segment      = seg;
    r.offset       = off;
    return r;
  endfunction

  function automatic req_t pick_request();
    req_t        r;
    int unsigned roll;
    logic [63:0] base;
    base = sb.arena_base;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      r = far_req({$urandom, $urandom});
      if (roll < 4) begin
        r.host_address = '0;
      end else if (roll < 34) begin
        r.host_address = base + 64'($urandom_range(0, 32'hF_FFFF));
      end else if (roll < 42) begin
        case ($urandom_range(0, 2))
          0:       r.host_address = base - 64'd1;
          1:       r.host_address = base + ARENA_BYTES - 64'd1;
          default: r.host_address = base + ARENA_BYTES;
        endcase
      end else if (roll < 72 && sb.pages_used != 0) begin
        r.host_address = {sb.page_keys[$urandom_range(0, sb.pages_used - 1)], 16'($urandom)};
      end
    end else begin
      r = host_req(16'($urandom), 16'($urandom));
      if (roll < 6) begin
        r.segment = '0;
        r.offset  = '0;
      end else if (roll < 12) begin
        r.segment = '0;
      end else if (roll < 40) begin
        r.segment = 16'($urandom_range(0, EXT_FIRST_SEG - 1));
      end else if (roll < 75 && sb.pages_used != 0) begin
        r.segment = EXT_FIRST_SEG + 16'($urandom_range(0, sb.pages_used - 1));
      end else if (roll < 90) begin
        r.segment = EXT_FIRST_SEG + 16'($urandom_range(sb.pages_used, 16'hFFFF - EXT_FIRST_SEG));
      end
    end
    return r;
  endfunction

  task automatic offer_request(req_t r);
    req_item  <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (sb.expected_translations.size() != 0) @(posedge clk);
  endtask

  task automatic write_arena_base(logic [63:0] value);
    wait_for_results();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.arena_base = value;
  endtask

  initial begin
    logic [63:0] base;
    sb = new();
    burst_left = $urandom_range(0, 12);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_request(far_req(64'h0));
    offer_request(host_req(16'h0, 16'h0));
    offer_request(far_req(ARENA_BYTES));
    offer_request(far_req(ARENA_BYTES + 64'hF_FFFF));
    offer_request(far_req(ARENA_BYTES - 64'd1));
    offer_request(far_req(ARENA_BYTES + ARENA_BYTES));
    offer_request(far_req(64'hFFFF_FFFF_FFFF_FFFF));
    offer_request(far_req(64'hFFFF_FFFF_FFFF_0000));
    offer_request(far_req(64'h1));
    offer_request(host_req(EXT_FIRST_SEG, 16'h0));
    offer_request(host_req(EXT_FIRST_SEG + 16'd2, 16'hFFFF));
    offer_request(host_req(EXT_FIRST_SEG + 16'd4, 16'h0));
    offer_request(host_req(16'hFFFF, 16'hFFFF));
    offer_request(host_req(16'h0, 16'h1));
    offer_request(host_req(EXT_FIRST_SEG - 16'd1, 16'hFFFF));
    offer_request(host_req(16'h1, 16'h0));
    offer_request(host_req(EXT_FIRST_SEG + 16'd3, 16'h1234));
    offer_request(far_req(64'hFFFF));

    write_arena_base(ARENA_BASE_MIN);
    for (int i = 0; i < 120; i++) begin
      if (i == 40) hold_req = 1'b1;
      offer_request(pick_request());
    end

    write_arena_base(ARENA_BASE_MAX);
    for (int i = 0; i < 120; i++) offer_request(pick_request());

    base = {$urandom, $urandom};
    if (base < ARENA_BASE_MIN) base = ARENA_BASE_MIN;
    if (base > ARENA_BASE_MAX) base = ARENA_BASE_MAX;
    write_arena_base(base);
    // fill the page table, then run against a full one
    while (sb.pages_used < SLOTS) begin
      if ($urandom_range(0, 9) != 0) offer_request(far_req({$urandom, $urandom}));
      else offer_request(pick_request());
    end
    offer_request(host_req(EXT_FIRST_SEG + 16'(SLOTS - 1), 16'hFFFF));
    offer_request(host_req(EXT_FIRST_SEG + 16'(SLOTS), 16'h0));
    offer_request(far_req({$urandom, $urandom}));
    for (int i = 0; i < 80; i++) offer_request(pick_request());

    wait_for_results();
    repeat (20) @(posedge clk);
    if (sb.expected_translations.size() != 0)
      $display("%0d expected items never arrived", sb.expected_translations.size());
    if (sb.mismatches == 0 && sb.expected_translations.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
